>>> hdl/zyz_pkg.sv
`timescale 1ns / 1ps
package zyz_pkg;
	localparam int CORDIC_STEPS = 14;
	localparam int ANG_W = 24;
	localparam int TRIG_W = 34;
	localparam int OUT_W = 16;

	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [OUT_W-1:0] out_t;

	localparam ang_t ANG_PI = ang_t'(3294199);
	localparam ang_t ANG_HALF_PI = ang_t'(1647099);
	localparam trig_t KINV_Q30 = trig_t'(652032874);
	localparam out_t OUT_MAX = out_t'(25736);

	function automatic ang_t atan_val(input int idx);
		ang_t r;
		case (idx)
			0: r = ang_t'(823550);
			1: r = ang_t'(486170);
			2: r = ang_t'(256879);
			3: r = ang_t'(130396);
			4: r = ang_t'(65451);
			5: r = ang_t'(32757);
			6: r = ang_t'(16383);
			7: r = ang_t'(8192);
			8: r = ang_t'(4096);
			9: r = ang_t'(2048);
			10: r = ang_t'(1024);
			11: r = ang_t'(512);
			12: r = ang_t'(256);
			13: r = ang_t'(128);
			14: r = ang_t'(64);
			15: r = ang_t'(32);
			16: r = ang_t'(16);
			17: r = ang_t'(8);
			18: r = ang_t'(4);
			19: r = ang_t'(2);
			20: r = ang_t'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic out_t rnd_sat(input ang_t v);
		logic signed [ANG_W:0] t;
		logic signed [ANG_W:0] mx;
		out_t r;
		t = ((ANG_W+1)'(v) + (ANG_W+1)'(64)) >>> 7;
		mx = (ANG_W+1)'(OUT_MAX);
		if (t > mx) begin
			r = OUT_MAX;
		end else if (t < -mx) begin
			r = -OUT_MAX;
		end else begin
			r = t[OUT_W-1:0];
		end
		return r;
	endfunction
endpackage

>>> hdl/zyz_in_if.sv
`timescale 1ns / 1ps
interface zyz_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] r00;
	logic signed [15:0] r01;
	logic signed [15:0] r02;
	logic signed [15:0] r10;
	logic signed [15:0] r11;
	logic signed [15:0] r12;
	logic signed [15:0] r22;
	modport source (output valid, r00, r01, r02, r10, r11, r12, r22, input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r22, output ready);
endinterface

>>> hdl/zyz_out_if.sv
`timescale 1ns / 1ps
interface zyz_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] angle_a;
	logic signed [15:0] angle_b;
	logic signed [15:0] angle_c;
	modport source (output valid, angle_a, angle_b, angle_c, input ready);
	modport sink (input valid, angle_a, angle_b, angle_c, output ready);
endinterface

>>> hdl/zyz_euler_from_rotation_top.sv
`timescale 1ns / 1ps
// z-y-z euler angles from a rotation matrix
// mat: request carries r00, r01, r02, r10, r11, r12, r22 in signed q2.14
// ang: request carries angle_a, angle_b, angle_c in signed q3.13 radians,
//      saturated to plus or minus pi
// one request is taken every cycle while ang is not stalled; each gives exactly one result
// stages in order: input register, alpha vectoring cordic, sin/cos rotation
// cordic, multiply stage, add stage, beta and gamma vectoring cordics side by
// side, output register
// every stage holds one request and moves only when the output register is
// empty or being taken, so mat.ready equals !ang.valid || ang.ready
// a stall on ang freezes the whole pipeline; nothing is lost or repeated
// reset clears all valid bits; the block is ready in the first cycle after
// reset is released
module zyz_euler_from_rotation_top #(
	parameter int CORDIC_STEPS = zyz_pkg::CORDIC_STEPS
) (
	input logic clk,
	input logic arst_n,
	zyz_in_if.sink mat,
	zyz_out_if.source ang
);
	localparam int WA = 36;
	localparam int WB = 54;
	localparam int PW = 50;
	localparam int SA = 112;
	localparam int SR = SA + zyz_pkg::ANG_W;
	localparam int HA = zyz_pkg::ANG_W / 2;

	logic en;
	logic v_s1;
	logic signed [15:0] r00_s1, r01_s1, r02_s1, r10_s1, r11_s1, r12_s1, r22_s1;

	logic va_out;
	zyz_pkg::ang_t alpha;
	logic [SA-1:0] sa_out;

	logic vr_out;
	zyz_pkg::trig_t cs, sn;
	logic [SR-1:0] sr_out;
	logic signed [15:0] r00_r, r01_r, r02_r, r10_r, r11_r, r12_r, r22_r;
	zyz_pkg::ang_t alpha_r;

	logic v_s2;
	logic signed [PW-1:0] pbc_s2, pbs_s2, pgs_s2, pgc_s2, pds_s2, pdc_s2;
	logic signed [15:0] r22_s2;
	zyz_pkg::ang_t alpha_s2;

	logic v_s3;
	logic signed [WB-1:0] bn_s3, bx_s3, gn_s3, gd_s3;
	zyz_pkg::ang_t alpha_s3;

	logic vb_out, vg_out;
	zyz_pkg::ang_t beta, gamma;
	logic [HA-1:0] ahi, alo;

	logic v_s4;
	zyz_pkg::out_t a_s4, b_s4, c_s4;

	assign en = !v_s4 || ang.ready;
	assign mat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= mat.valid;
			v_s2 <= vr_out;
			v_s3 <= v_s2;
			v_s4 <= vb_out && vg_out;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r00_s1 <= mat.r00;
			r01_s1 <= mat.r01;
			r02_s1 <= mat.r02;
			r10_s1 <= mat.r10;
			r11_s1 <= mat.r11;
			r12_s1 <= mat.r12;
			r22_s1 <= mat.r22;
		end
	end

	// alpha = atan2(r12, r02)
	zyz_vec #(.W(WA), .STEPS(CORDIC_STEPS), .SW(SA)) u_vec_a (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s1),
		.x_in(WA'(r02_s1) <<< 16),
		.y_in(WA'(r12_s1) <<< 16),
		.side_in({r00_s1, r01_s1, r02_s1, r10_s1, r11_s1, r12_s1, r22_s1}),
		.out_valid(va_out),
		.z_out(alpha),
		.side_out(sa_out)
	);

	zyz_rot #(.STEPS(CORDIC_STEPS), .SW(SR)) u_rot (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(va_out),
		.z_in(alpha),
		.side_in({alpha, sa_out}),
		.out_valid(vr_out),
		.cos_out(cs),
		.sin_out(sn),
		.side_out(sr_out)
	);

	assign {alpha_r, r00_r, r01_r, r02_r, r10_r, r11_r, r12_r, r22_r} = sr_out;

	always_ff @(posedge clk) begin
		if (en) begin
			pbc_s2 <= r02_r * cs;
			pbs_s2 <= r12_r * sn;
			pgs_s2 <= r00_r * sn;
			pgc_s2 <= r10_r * cs;
			pds_s2 <= r01_r * sn;
			pdc_s2 <= r11_r * cs;
			r22_s2 <= r22_r;
			alpha_s2 <= alpha_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bn_s3 <= WB'(pbc_s2) + WB'(pbs_s2);
			bx_s3 <= WB'(r22_s2) <<< 30;
			gn_s3 <= WB'(pgc_s2) - WB'(pgs_s2);
			gd_s3 <= WB'(pdc_s2) - WB'(pds_s2);
			alpha_s3 <= alpha_s2;
		end
	end

	zyz_vec #(.W(WB), .STEPS(CORDIC_STEPS), .SW(HA)) u_vec_b (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s3),
		.x_in(bx_s3),
		.y_in(bn_s3),
		.side_in(alpha_s3[zyz_pkg::ANG_W-1:HA]),
		.out_valid(vb_out),
		.z_out(beta),
		.side_out(ahi)
	);

	zyz_vec #(.W(WB), .STEPS(CORDIC_STEPS), .SW(HA)) u_vec_c (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s3),
		.x_in(gd_s3),
		.y_in(gn_s3),
		.side_in(alpha_s3[HA-1:0]),
		.out_valid(vg_out),
		.z_out(gamma),
		.side_out(alo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4 <= zyz_pkg::rnd_sat({ahi, alo});
			b_s4 <= zyz_pkg::rnd_sat(beta);
			c_s4 <= zyz_pkg::rnd_sat(gamma);
		end
	end

	assign ang.valid = v_s4;
	assign ang.angle_a = a_s4;
	assign ang.angle_b = b_s4;
	assign ang.angle_c = c_s4;
endmodule

>>> hdl/zyz_vec.sv
`timescale 1ns / 1ps
module zyz_vec #(
	parameter int W = 36,
	parameter int STEPS = zyz_pkg::CORDIC_STEPS,
	parameter int SW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [W-1:0] x_in,
	input logic signed [W-1:0] y_in,
	input logic [SW-1:0] side_in,
	output logic out_valid,
	output zyz_pkg::ang_t z_out,
	output logic [SW-1:0] side_out
);
	logic signed [W-1:0] x_s [0:STEPS];
	logic signed [W-1:0] y_s [0:STEPS];
	zyz_pkg::ang_t z_s [0:STEPS];
	logic zr_s [0:STEPS];
	logic [SW-1:0] sd_s [0:STEPS];
	logic vl_s [0:STEPS];

	// fold left half plane onto right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_s[0] <= 1'b0;
		end else if (en) begin
			vl_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zr_s[0] <= (x_in == '0) && (y_in == '0);
			sd_s[0] <= side_in;
			if (x_in[W-1]) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= y_in[W-1] ? -zyz_pkg::ANG_PI : zyz_pkg::ANG_PI;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s[i+1] <= 1'b0;
			end else if (en) begin
				vl_s[i+1] <= vl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zr_s[i+1] <= zr_s[i];
				sd_s[i+1] <= sd_s[i];
				if (!y_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + zyz_pkg::atan_val(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - zyz_pkg::atan_val(i);
				end
			end
		end
	end

	assign out_valid = vl_s[STEPS];
	assign z_out = zr_s[STEPS] ? '0 : z_s[STEPS];
	assign side_out = sd_s[STEPS];
endmodule

>>> hdl/zyz_rot.sv
`timescale 1ns / 1ps
module zyz_rot #(
	parameter int STEPS = zyz_pkg::CORDIC_STEPS,
	parameter int SW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input zyz_pkg::ang_t z_in,
	input logic [SW-1:0] side_in,
	output logic out_valid,
	output zyz_pkg::trig_t cos_out,
	output zyz_pkg::trig_t sin_out,
	output logic [SW-1:0] side_out
);
	zyz_pkg::trig_t x_s [0:STEPS];
	zyz_pkg::trig_t y_s [0:STEPS];
	zyz_pkg::ang_t z_s [0:STEPS];
	logic fl_s [0:STEPS];
	logic [SW-1:0] sd_s [0:STEPS];
	logic vl_s [0:STEPS];
	zyz_pkg::trig_t c_q;
	zyz_pkg::trig_t s_q;
	logic [SW-1:0] sd_q;
	logic vl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_s[0] <= 1'b0;
			vl_q <= 1'b0;
		end else if (en) begin
			vl_s[0] <= in_valid;
			vl_q <= vl_s[STEPS];
		end
	end

	// bring angle into plus or minus half pi
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= zyz_pkg::KINV_Q30;
			y_s[0] <= '0;
			sd_s[0] <= side_in;
			if (z_in > zyz_pkg::ANG_HALF_PI) begin
				z_s[0] <= z_in - zyz_pkg::ANG_PI;
				fl_s[0] <= 1'b1;
			end else if (z_in < -zyz_pkg::ANG_HALF_PI) begin
				z_s[0] <= z_in + zyz_pkg::ANG_PI;
				fl_s[0] <= 1'b1;
			end else begin
				z_s[0] <= z_in;
				fl_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s[i+1] <= 1'b0;
			end else if (en) begin
				vl_s[i+1] <= vl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fl_s[i+1] <= fl_s[i];
				sd_s[i+1] <= sd_s[i];
				if (!z_s[i][zyz_pkg::ANG_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - zyz_pkg::atan_val(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + zyz_pkg::atan_val(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q <= fl_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
			s_q <= fl_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
			sd_q <= sd_s[STEPS];
		end
	end

	assign out_valid = vl_q;
	assign cos_out = c_q;
	assign sin_out = s_q;
	assign side_out = sd_q;
endmodule

>>> hdl/zyz_chk.sv
`timescale 1ns / 1ps
module zyz_chk (
	input logic clk,
	input logic arst_n,
	input logic mat_ready,
	input logic ang_valid,
	input logic ang_ready,
	input logic signed [15:0] angle_a,
	input logic signed [15:0] angle_b,
	input logic signed [15:0] angle_c
);
	a_no_valid_in_reset: assert property (@(posedge clk) !arst_n |=> !ang_valid)
		else $error("result valid during reset");

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		mat_ready == (!ang_valid || ang_ready))
		else $error("input ready does not follow output stall");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ang_valid && !ang_ready |=> ang_valid && $stable(angle_a) && $stable(angle_b)
			&& $stable(angle_c))
		else $error("stalled result changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		ang_valid |-> angle_a <= 16'sd25736 && angle_a >= -16'sd25736
			&& angle_b <= 16'sd25736 && angle_b >= -16'sd25736
			&& angle_c <= 16'sd25736 && angle_c >= -16'sd25736)
		else $error("angle beyond pi");
endmodule

bind zyz_euler_from_rotation_top zyz_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.mat_ready(mat.ready),
	.ang_valid(ang.valid),
	.ang_ready(ang.ready),
	.angle_a(ang.angle_a),
	.angle_b(ang.angle_b),
	.angle_c(ang.angle_c)
);
